// File: design/ssmp_pkg.sv
// Shared constants, operation and status codes, and pipeline control word type.
package ssmp_pkg;

  localparam int SUM_BITS           = 24;
  localparam int OP_BITS            = 2;
  localparam int STATUS_BITS        = 2;
  localparam int MAX_STEPS_DEF      = 256;
  localparam int WEIGHT_BITS_DEF    = 16;
  localparam int FRACTION_BITS_DEF  = 16;

  typedef enum logic [OP_BITS-1:0] {
    OP_LOAD   = 2'd0,
    OP_SAMPLE = 2'd1,
    OP_QUERY  = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  // Control word that travels along the cell chain with each item.
  typedef struct packed {
    logic    valid;
    op_t     op;
    status_t status;
  } ctl_t;

endpackage

// File: design/ssmp_req_if.sv
// Request channel: valid/ready handshake carrying one input word.
interface ssmp_req_if #(
  parameter int WEIGHT_BITS   = ssmp_pkg::WEIGHT_BITS_DEF,
  parameter int FRACTION_BITS = ssmp_pkg::FRACTION_BITS_DEF,
  parameter int INDEX_BITS    = $clog2(ssmp_pkg::MAX_STEPS_DEF)
);
  logic                         valid;
  logic                         ready;
  logic [ssmp_pkg::OP_BITS-1:0] operation;
  logic [WEIGHT_BITS-1:0]       weight;
  logic                         last;
  logic [FRACTION_BITS-1:0]     random_fraction;
  logic [INDEX_BITS-1:0]        query_index;

  modport source (
    output valid, operation, weight, last, random_fraction, query_index,
    input  ready
  );
  modport sink (
    input  valid, operation, weight, last, random_fraction, query_index,
    output ready
  );
endinterface

// File: design/ssmp_rsp_if.sv
// Response channel: valid/ready handshake carrying one result word.
interface ssmp_rsp_if #(
  parameter int WEIGHT_BITS = ssmp_pkg::WEIGHT_BITS_DEF,
  parameter int INDEX_BITS  = $clog2(ssmp_pkg::MAX_STEPS_DEF),
  parameter int COUNT_BITS  = $clog2(ssmp_pkg::MAX_STEPS_DEF + 1)
);
  logic                             valid;
  logic                             ready;
  logic [INDEX_BITS-1:0]            chosen_step;
  logic [WEIGHT_BITS-1:0]           step_weight;
  logic [ssmp_pkg::SUM_BITS-1:0]    total_weight;
  logic [COUNT_BITS-1:0]            step_count;
  logic [ssmp_pkg::STATUS_BITS-1:0] status;

  modport source (
    output valid, chosen_step, step_weight, total_weight, step_count, status,
    input  ready
  );
  modport sink (
    input  valid, chosen_step, step_weight, total_weight, step_count, status,
    output ready
  );
endinterface

// File: design/step_distribution_sampler.sv
// Top level: head stage, a row of MAX_STEPS sum cells, and the result register.
// Path: the head stage registers an accepted word, each cell registers it in turn, and the
// result register then holds it until the sink takes it.
// Throughput: one word per cycle; stalls only while a result waits at the output
// and another word has reached the end of the chain.
// Reset: clears total, count and valid bits, marks the table complete; sums stay undefined.
module step_distribution_sampler #(
  parameter int MAX_STEPS     = ssmp_pkg::MAX_STEPS_DEF,
  parameter int WEIGHT_BITS   = ssmp_pkg::WEIGHT_BITS_DEF,
  parameter int FRACTION_BITS = ssmp_pkg::FRACTION_BITS_DEF
) (
  input logic        clk,
  input logic        rst,
  ssmp_req_if.sink   req,
  ssmp_rsp_if.source rsp
);
  localparam int SB = ssmp_pkg::SUM_BITS;
  localparam int CW = $clog2(MAX_STEPS + 1);
  localparam int IW = $clog2(MAX_STEPS);
  localparam int TW = SB + FRACTION_BITS;

  // Chain taps: index 0 is the head stage, index k the output of cell k.
  ssmp_pkg::ctl_t chain_ctl    [0:MAX_STEPS];
  logic [CW-1:0]  chain_pos    [0:MAX_STEPS];
  logic [TW-1:0]  chain_arg    [0:MAX_STEPS];
  logic [IW-1:0]  chain_chosen [0:MAX_STEPS];
  logic [SB-1:0]  chain_total  [0:MAX_STEPS];
  logic [CW-1:0]  chain_count  [0:MAX_STEPS];

  logic advance;
  logic out_load;
  logic out_valid;

  logic [IW-1:0]                    out_chosen;
  logic [WEIGHT_BITS-1:0]           out_weight;
  logic [SB-1:0]                    out_total;
  logic [CW-1:0]                    out_count;
  logic [ssmp_pkg::STATUS_BITS-1:0] out_status;

  // The result register takes a word when empty or being drained. The whole
  // chain moves unless the tail holds a word that has nowhere to go, so bubbles
  // drain out even while a result waits.
  assign out_load = !out_valid || rsp.ready;
  assign advance  = out_load || !chain_ctl[MAX_STEPS].valid;

  ssmp_head #(
    .MAX_STEPS     (MAX_STEPS),
    .WEIGHT_BITS   (WEIGHT_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_head (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .req       (req),
    .ctl_out   (chain_ctl[0]),
    .pos_out   (chain_pos[0]),
    .arg_out   (chain_arg[0]),
    .total_out (chain_total[0]),
    .count_out (chain_count[0])
  );

  // No step chosen until a cell says otherwise.
  assign chain_chosen[0] = '0;

  // Cell k holds the running sum at entry k (the sum before entry 1 is zero).
  for (genvar k = 1; k <= MAX_STEPS; k++) begin : g_cell
    ssmp_cell #(
      .CELL_INDEX    (k),
      .MAX_STEPS     (MAX_STEPS),
      .FRACTION_BITS (FRACTION_BITS)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .advance    (advance),
      .ctl_in     (chain_ctl[k-1]),
      .pos_in     (chain_pos[k-1]),
      .arg_in     (chain_arg[k-1]),
      .chosen_in  (chain_chosen[k-1]),
      .total_in   (chain_total[k-1]),
      .count_in   (chain_count[k-1]),
      .ctl_out    (chain_ctl[k]),
      .pos_out    (chain_pos[k]),
      .arg_out    (chain_arg[k]),
      .chosen_out (chain_chosen[k]),
      .total_out  (chain_total[k]),
      .count_out  (chain_count[k])
    );
  end

  // Result register: hold while stalled, advance the tail word when free.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= chain_ctl[MAX_STEPS].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_chosen <= chain_chosen[MAX_STEPS];
      out_weight <= (chain_ctl[MAX_STEPS].op == ssmp_pkg::OP_QUERY)
                    ? chain_arg[MAX_STEPS][WEIGHT_BITS-1:0] : '0;
      out_total  <= chain_total[MAX_STEPS];
      out_count  <= chain_count[MAX_STEPS];
      out_status <= chain_ctl[MAX_STEPS].status;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.chosen_step  = out_chosen;
  assign rsp.step_weight  = out_weight;
  assign rsp.total_weight = out_total;
  assign rsp.step_count   = out_count;
  assign rsp.status       = out_status;

endmodule

// File: design/ssmp_head.sv
// Head stage: accepts request words, keeps total/count/complete, seeds the cell chain.
module ssmp_head #(
  parameter int MAX_STEPS     = ssmp_pkg::MAX_STEPS_DEF,
  parameter int WEIGHT_BITS   = ssmp_pkg::WEIGHT_BITS_DEF,
  parameter int FRACTION_BITS = ssmp_pkg::FRACTION_BITS_DEF
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       advance,
  ssmp_req_if.sink                                   req,
  output ssmp_pkg::ctl_t                             ctl_out,
  output logic [$clog2(MAX_STEPS+1)-1:0]             pos_out,
  output logic [ssmp_pkg::SUM_BITS+FRACTION_BITS-1:0] arg_out,
  output logic [ssmp_pkg::SUM_BITS-1:0]              total_out,
  output logic [$clog2(MAX_STEPS+1)-1:0]             count_out
);
  localparam int SB = ssmp_pkg::SUM_BITS;
  localparam int CW = $clog2(MAX_STEPS + 1);
  localparam int IW = $clog2(MAX_STEPS);
  localparam int TW = SB + FRACTION_BITS;
  localparam int AW = (SB > WEIGHT_BITS) ? SB + 1 : WEIGHT_BITS + 1;
  localparam logic [CW-1:0] FULL_COUNT = CW'(MAX_STEPS);

  logic [SB-1:0] total;
  logic [CW-1:0] count;
  logic          complete;

  logic [SB-1:0] total_next;
  logic [CW-1:0] count_next;
  logic          complete_next;

  ssmp_pkg::ctl_t     ctl_next;
  logic [CW-1:0]      pos_next;
  logic [TW-1:0]      arg_next;
  logic               accept;
  ssmp_pkg::op_t      op;
  logic [SB-1:0]      total_base;
  logic [CW-1:0]      count_base;
  logic [AW-1:0]      load_sum;
  logic [TW-1:0]      product;
  logic [WEIGHT_BITS-1:0]   weight_in;
  logic [FRACTION_BITS-1:0] fraction_in;
  logic [IW-1:0]            index_in;

  // Hold off the sender while reset is applied.
  assign req.ready   = advance && !rst;
  assign accept      = req.valid && req.ready;
  assign op          = ssmp_pkg::op_t'(req.operation);
  assign weight_in   = WEIGHT_BITS'(req.weight);
  assign fraction_in = FRACTION_BITS'(req.random_fraction);
  assign index_in    = IW'(req.query_index);

  // A load after a completed table restarts it.
  assign total_base = complete ? '0 : total;
  assign count_base = complete ? '0 : count;
  assign load_sum   = AW'(total_base) + AW'(weight_in);
  assign product    = TW'(fraction_in) * TW'(total);

  always_comb begin
    ctl_next      = '{valid: 1'b1, op: ssmp_pkg::OP_NONE, status: ssmp_pkg::ST_OK};
    pos_next      = '0;
    arg_next      = '0;
    total_next    = total;
    count_next    = count;
    complete_next = complete;
    unique case (op)
      ssmp_pkg::OP_LOAD: begin
        complete_next = req.last;
        total_next    = total_base;
        count_next    = count_base;
        if (count_base == FULL_COUNT || load_sum[AW-1:SB] != '0) begin
          ctl_next.status = ssmp_pkg::ST_FULL;
        end else begin
          ctl_next.op = ssmp_pkg::OP_LOAD;
          total_next  = load_sum[SB-1:0];
          count_next  = count_base + CW'(1);
          pos_next    = count_base + CW'(1);
          arg_next    = TW'(load_sum[SB-1:0]);
        end
      end
      ssmp_pkg::OP_SAMPLE: begin
        if (count == '0 || total == '0) begin
          ctl_next.status = ssmp_pkg::ST_EMPTY;
        end else begin
          ctl_next.op = ssmp_pkg::OP_SAMPLE;
          pos_next    = count;
          arg_next    = product;
        end
      end
      ssmp_pkg::OP_QUERY: begin
        if (CW'(index_in) >= count) begin
          ctl_next.status = ssmp_pkg::ST_RANGE;
        end else begin
          ctl_next.op = ssmp_pkg::OP_QUERY;
          pos_next    = CW'(index_in);
        end
      end
      ssmp_pkg::OP_NONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total    <= '0;
      count    <= '0;
      complete <= 1'b1;
      ctl_out  <= '0;
    end else if (advance) begin
      ctl_out <= accept ? ctl_next : '0;
      if (accept) begin
        total    <= total_next;
        count    <= count_next;
        complete <= complete_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      pos_out   <= pos_next;
      arg_out   <= arg_next;
      total_out <= total_next;
      count_out <= count_next;
    end
  end

endmodule

// File: design/ssmp_cell.sv
// One chain cell: holds one running sum, serves the word passing through it.
module ssmp_cell #(
  parameter int CELL_INDEX    = 1,
  parameter int MAX_STEPS     = ssmp_pkg::MAX_STEPS_DEF,
  parameter int FRACTION_BITS = ssmp_pkg::FRACTION_BITS_DEF
) (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         advance,
  input  ssmp_pkg::ctl_t                               ctl_in,
  input  logic [$clog2(MAX_STEPS+1)-1:0]               pos_in,
  input  logic [ssmp_pkg::SUM_BITS+FRACTION_BITS-1:0]  arg_in,
  input  logic [$clog2(MAX_STEPS)-1:0]                 chosen_in,
  input  logic [ssmp_pkg::SUM_BITS-1:0]                total_in,
  input  logic [$clog2(MAX_STEPS+1)-1:0]               count_in,
  output ssmp_pkg::ctl_t                               ctl_out,
  output logic [$clog2(MAX_STEPS+1)-1:0]               pos_out,
  output logic [ssmp_pkg::SUM_BITS+FRACTION_BITS-1:0]  arg_out,
  output logic [$clog2(MAX_STEPS)-1:0]                 chosen_out,
  output logic [ssmp_pkg::SUM_BITS-1:0]                total_out,
  output logic [$clog2(MAX_STEPS+1)-1:0]               count_out
);
  localparam int SB = ssmp_pkg::SUM_BITS;
  localparam int CW = $clog2(MAX_STEPS + 1);
  localparam int IW = $clog2(MAX_STEPS);
  localparam int TW = SB + FRACTION_BITS;
  localparam logic [CW-1:0] CELL_POS   = CW'(CELL_INDEX);
  localparam logic [IW-1:0] CELL_STEP  = IW'(CELL_INDEX);

  logic [SB-1:0] sum;
  logic [SB-1:0] sum_next;
  logic [TW-1:0] arg_next;
  logic [IW-1:0] chosen_next;

  always_comb begin
    sum_next    = sum;
    arg_next    = arg_in;
    chosen_next = chosen_in;
    if (ctl_in.valid) begin
      unique case (ctl_in.op)
        ssmp_pkg::OP_LOAD: begin
          if (pos_in == CELL_POS) sum_next = arg_in[SB-1:0];
        end
        ssmp_pkg::OP_SAMPLE: begin
          // Sums are monotone, so every passing cell lies below the first failing one.
          if (CELL_POS < pos_in && {sum, {FRACTION_BITS{1'b0}}} <= arg_in) begin
            chosen_next = CELL_STEP;
          end
        end
        ssmp_pkg::OP_QUERY: begin
          // Capture the lower sum, then take the difference one cell further.
          if (pos_in == CELL_POS) begin
            arg_next = TW'(sum);
          end else if (pos_in + CW'(1) == CELL_POS) begin
            arg_next = TW'(sum - arg_in[SB-1:0]);
          end
        end
        ssmp_pkg::OP_NONE: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else if (advance) begin
      ctl_out <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      sum        <= sum_next;
      pos_out    <= pos_in;
      arg_out    <= arg_next;
      chosen_out <= chosen_next;
      total_out  <= total_in;
      count_out  <= count_in;
    end
  end

endmodule

// File: sim/tb.sv
// Testbench for step_distribution_sampler: directed table, random sessions, scoreboard.
`timescale 1ns / 100ps

module tb;

  localparam int CLK_PERIOD = 8;
  localparam int MAX_STEPS  = ssmp_pkg::MAX_STEPS_DEF;
  // Long enough that the sender can fill the whole cell chain behind a stalled output.
  localparam int HOLD_CYCLES = 3 * MAX_STEPS;
  localparam int TIMEOUT_NS  = 2_000_000;
  localparam int PHASE_WORDS = 35;
  localparam int N_DIRECTED  = 24;

  // One request word as the predictor sees it.
  typedef struct packed {
    ssmp_pkg::op_t op;
    logic [15:0]   weight;
    logic          last;
    logic [15:0]   frac;
    logic [7:0]    idx;
  } step_word_t;

  // One result word, field for field as the response channel carries it.
  typedef struct packed {
    logic [7:0]        chosen;
    logic [15:0]       weight;
    logic [23:0]       total;
    logic [8:0]        count;
    ssmp_pkg::status_t status;
  } step_result_t;

  // A directed row: the word, and the result typed in where it is obvious.
  typedef struct packed {
    step_word_t   word;
    logic         typed;
    step_result_t want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst;

  ssmp_req_if req_ch ();
  ssmp_rsp_if rsp_ch ();

  step_distribution_sampler dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Predictor copy of the block state: running sums, total, count, completion flag.
  logic [23:0] sum_tbl [0:MAX_STEPS];
  logic [23:0] tot_sum;
  logic [8:0]  n_loaded;
  logic        tbl_done;

  step_result_t awaited_results [$];
  int          mismatches = 0;
  int          words_sent = 0;
  int          tx_idle_pct = 0;
  int          rx_stall_pct = 0;
  logic        hold_req = 1'b0;

  // Directed table. Rows with typed = 1 carry a result worked out by hand
  // (reset state, zero totals, extremes, error codes); the rest lean on
  // the predictor.
  stim_row_t directed_rows [0:N_DIRECTED-1] = '{
    // sample right after reset: empty table
    '{'{ssmp_pkg::OP_SAMPLE, 16'h0000, 1'b0, 16'h1234, 8'h00}, 1'b1,
      '{8'd0, 16'd0, 24'd0, 9'd0, ssmp_pkg::ST_EMPTY}},
    // queries on an empty table are always out of range
    '{'{ssmp_pkg::OP_QUERY, 16'h0000, 1'b0, 16'h0000, 8'h00}, 1'b1,
      '{8'd0, 16'd0, 24'd0, 9'd0, ssmp_pkg::ST_RANGE}},
    '{'{ssmp_pkg::OP_QUERY, 16'hFFFF, 1'b1, 16'hFFFF, 8'hFF}, 1'b1,
      '{8'd0, 16'd0, 24'd0, 9'd0, ssmp_pkg::ST_RANGE}},
    // reserved operation with every payload bit set changes nothing
    '{'{ssmp_pkg::OP_NONE, 16'hFFFF, 1'b1, 16'hFFFF, 8'hFF}, 1'b1,
      '{8'd0, 16'd0, 24'd0, 9'd0, ssmp_pkg::ST_OK}},
    // zero weight: one step, total still zero
    '{'{ssmp_pkg::OP_LOAD, 16'h0000, 1'b0, 16'hFFFF, 8'hFF}, 1'b1,
      '{8'd0, 16'd0, 24'd0, 9'd1, ssmp_pkg::ST_OK}},
    // zero total: sample reports empty
    '{'{ssmp_pkg::OP_SAMPLE, 16'h0000, 1'b0, 16'hFFFF, 8'h00}, 1'b1,
      '{8'd0, 16'd0, 24'd0, 9'd1, ssmp_pkg::ST_EMPTY}},
    '{'{ssmp_pkg::OP_QUERY, 16'h0000, 1'b0, 16'h0000, 8'h00}, 1'b1,
      '{8'd0, 16'd0, 24'd0, 9'd1, ssmp_pkg::ST_OK}},
    '{'{ssmp_pkg::OP_LOAD, 16'hFFFF, 1'b0, 16'h0000, 8'h00}, 1'b1,
      '{8'd0, 16'd0, 24'd65535, 9'd2, ssmp_pkg::ST_OK}},
    '{'{ssmp_pkg::OP_LOAD, 16'h0000, 1'b0, 16'h0000, 8'h00}, 1'b1,
      '{8'd0, 16'd0, 24'd65535, 9'd3, ssmp_pkg::ST_OK}},
    '{'{ssmp_pkg::OP_LOAD, 16'h0001, 1'b1, 16'h0000, 8'h00}, 1'b1,
      '{8'd0, 16'd0, 24'd65536, 9'd4, ssmp_pkg::ST_OK}},
    // fraction extremes and midpoint against a table with zero-weight steps
    '{'{ssmp_pkg::OP_SAMPLE, 16'h0000, 1'b0, 16'h0000, 8'h00}, 1'b0, '0},
    '{'{ssmp_pkg::OP_SAMPLE, 16'h0000, 1'b0, 16'hFFFF, 8'h00}, 1'b0, '0},
    '{'{ssmp_pkg::OP_SAMPLE, 16'h0000, 1'b0, 16'h8000, 8'h00}, 1'b0, '0},
    '{'{ssmp_pkg::OP_QUERY, 16'h0000, 1'b0, 16'h0000, 8'h01}, 1'b1,
      '{8'd0, 16'hFFFF, 24'd65536, 9'd4, ssmp_pkg::ST_OK}},
    '{'{ssmp_pkg::OP_QUERY, 16'h0000, 1'b0, 16'h0000, 8'h03}, 1'b0, '0},
    // first index past the end
    '{'{ssmp_pkg::OP_QUERY, 16'h0000, 1'b0, 16'h0000, 8'h04}, 1'b1,
      '{8'd0, 16'd0, 24'd65536, 9'd4, ssmp_pkg::ST_RANGE}},
    // load after a completed table restarts it
    '{'{ssmp_pkg::OP_LOAD, 16'h0007, 1'b1, 16'h0000, 8'h00}, 1'b1,
      '{8'd0, 16'd0, 24'd7, 9'd1, ssmp_pkg::ST_OK}},
    '{'{ssmp_pkg::OP_SAMPLE, 16'h0000, 1'b0, 16'hFFFF, 8'h00}, 1'b0, '0},
    '{'{ssmp_pkg::OP_LOAD, 16'hFFFF, 1'b0, 16'h0000, 8'h00}, 1'b1,
      '{8'd0, 16'd0, 24'd65535, 9'd1, ssmp_pkg::ST_OK}},
    // sample while the table is still being loaded
    '{'{ssmp_pkg::OP_SAMPLE, 16'h0000, 1'b0, 16'h4000, 8'h00}, 1'b0, '0},
    '{'{ssmp_pkg::OP_LOAD, 16'h0000, 1'b1, 16'h0000, 8'h00}, 1'b0, '0},
    '{'{ssmp_pkg::OP_NONE, 16'h0000, 1'b0, 16'h0000, 8'h00}, 1'b1,
      '{8'd0, 16'd0, 24'd65535, 9'd2, ssmp_pkg::ST_OK}},
    '{'{ssmp_pkg::OP_QUERY, 16'h0000, 1'b0, 16'h0000, 8'h01}, 1'b0, '0},
    // trailing zero-weight step must never be drawn, even at the top fraction
    '{'{ssmp_pkg::OP_SAMPLE, 16'h0000, 1'b0, 16'hFFFF, 8'h00}, 1'b0, '0}
  };

  // Advance the predictor state by one accepted word and return its result.
  function automatic step_result_t step_table_result(input step_word_t w);
    step_result_t r;
    logic [24:0]  grown;
    logic [39:0]  target;
    logic         scanning;
    int           i;
    r = '0;
    case (w.op)
      ssmp_pkg::OP_LOAD: begin
        if (tbl_done) begin
          n_loaded   = '0;
          tot_sum    = '0;
          sum_tbl[0] = '0;
          tbl_done   = 1'b0;
        end
        grown = {1'b0, tot_sum} + {9'd0, w.weight};
        // drop the weight once the table is full or the sum would wrap
        if (n_loaded >= MAX_STEPS || grown[24]) begin
          r.status = ssmp_pkg::ST_FULL;
        end else begin
          tot_sum           = grown[23:0];
          n_loaded          = n_loaded + 9'd1;
          sum_tbl[n_loaded] = tot_sum;
        end
        if (w.last) tbl_done = 1'b1;
      end
      ssmp_pkg::OP_SAMPLE: begin
        if (n_loaded == 0 || tot_sum == 0) begin
          r.status = ssmp_pkg::ST_EMPTY;
        end else begin
          target   = 40'(w.frac) * 40'(tot_sum);
          scanning = 1'b1;
          // largest step whose left edge, scaled by 2^16, is still at or below u*total
          for (i = 1; i < n_loaded; i++) begin
            if (scanning && {sum_tbl[i], 16'h0000} <= target) r.chosen = i[7:0];
            else scanning = 1'b0;
          end
        end
      end
      ssmp_pkg::OP_QUERY: begin
        if ({1'b0, w.idx} >= n_loaded) r.status = ssmp_pkg::ST_RANGE;
        else r.weight = 16'(sum_tbl[w.idx + 1] - sum_tbl[w.idx]);
      end
      default: ;
    endcase
    r.total = tot_sum;
    r.count = n_loaded;
    return r;
  endfunction

  // Offer one word, hold it until accepted, then queue its expected result.
  task automatic send_word(input step_word_t w, input logic typed = 1'b0,
                           input step_result_t want = '0);
    int           gap;
    step_result_t predicted;
    gap = ($urandom_range(99) < tx_idle_pct) ? $urandom_range(1, 5) : 0;
    if (gap != 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid           <= 1'b1;
    req_ch.operation       <= w.op;
    req_ch.weight          <= w.weight;
    req_ch.last            <= w.last;
    req_ch.random_fraction <= w.frac;
    req_ch.query_index     <= w.idx;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    predicted = step_table_result(w);
    if (typed) predicted = want;
    awaited_results = {awaited_results, predicted};
    words_sent++;
  endtask

  function automatic logic [15:0] rand_weight();
    case ($urandom_range(9))
      0, 1:    return 16'h0000;
      2:       return 16'hFFFF;
      3:       return 16'($urandom_range(1, 15));
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [15:0] rand_fraction();
    case ($urandom_range(7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // Random payload in every field, so ignored bits toggle too.
  function automatic step_word_t noise_word();
    step_word_t w;
    w.op     = ssmp_pkg::op_t'($urandom_range(3));
    w.weight = 16'($urandom_range(0, 65535));
    w.last   = 1'($urandom_range(1));
    w.frac   = 16'($urandom_range(0, 65535));
    w.idx    = 8'($urandom_range(0, 255));
    return w;
  endfunction

  // Mostly samples and queries near the live range; some reserved ops and stray loads.
  function automatic step_word_t random_read();
    step_word_t w;
    int         pick;
    int         top;
    w    = noise_word();
    pick = $urandom_range(19);
    top  = (n_loaded > 255) ? 255 : int'(n_loaded);
    if (pick < 9) begin
      w.op   = ssmp_pkg::OP_SAMPLE;
      w.frac = rand_fraction();
    end else if (pick < 17) begin
      w.op  = ssmp_pkg::OP_QUERY;
      w.idx = ($urandom_range(3) == 0) ? 8'($urandom_range(0, 255))
                                       : 8'($urandom_range(0, top));
    end else if (pick < 19) begin
      w.op = ssmp_pkg::OP_NONE;
    end else begin
      w.op     = ssmp_pkg::OP_LOAD;
      w.weight = rand_weight();
    end
    return w;
  endfunction

  // One table load, maybe interrupted by reads, then a burst of reads.
  // Now and then drop the closing last flag so the next session appends.
  task automatic run_session();
    int         n;
    int         m;
    int         k;
    step_word_t w;
    n = ($urandom_range(9) == 0) ? $urandom_range(20, 48) : $urandom_range(1, 8);
    for (k = 0; k < n; k++) begin
      if ($urandom_range(11) == 0) send_word(random_read());
      w        = noise_word();
      w.op     = ssmp_pkg::OP_LOAD;
      w.weight = rand_weight();
      w.last   = (k == n - 1) && ($urandom_range(9) != 0);
      send_word(w);
    end
    m = $urandom_range(2, 8);
    for (k = 0; k < m; k++) send_word(random_read());
  endtask

  // Fill every step with heavy weights while the output is held off, so the
  // chain backs up into the input. Then push past the end: a dropped weight,
  // and a dropped weight that still carries the last flag.
  task automatic run_full_table();
    int         k;
    step_word_t w;
    hold_req = 1'b1;
    for (k = 0; k < MAX_STEPS + 2; k++) begin
      w        = noise_word();
      w.op     = ssmp_pkg::OP_LOAD;
      w.weight = ($urandom_range(1) == 0) ? 16'hFFFF : 16'($urandom_range(60000, 65535));
      w.last   = (k == MAX_STEPS + 1);
      send_word(w);
    end
    w = noise_word(); w.op = ssmp_pkg::OP_SAMPLE; w.frac = 16'hFFFF; send_word(w);
    w = noise_word(); w.op = ssmp_pkg::OP_SAMPLE; send_word(w);
    w = noise_word(); w.op = ssmp_pkg::OP_QUERY;  w.idx = 8'hFF; send_word(w);
    w = noise_word(); w.op = ssmp_pkg::OP_QUERY;  w.idx = 8'h00; send_word(w);
  endtask

  task automatic run_phase(input int tx_pct, input int rx_pct);
    int start;
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    start        = words_sent;
    while (words_sent - start < PHASE_WORDS) run_session();
  endtask

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // Receiver: random stalls per phase, plus one long hold-off on request.
  initial begin : receiver
    int held;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        rsp_ch.ready <= 1'b0;
        for (held = 0; held < HOLD_CYCLES; held++) @(posedge clk);
        hold_req = 1'b0;
      end
      rsp_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // Scoreboard: every accepted result word against the oldest expectation.
  always @(posedge clk) begin : check_results
    step_result_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (awaited_results.size() == 0) begin
        $error("result word accepted with nothing expected");
        mismatches++;
      end else begin
        want = awaited_results.pop_front();
        check_field("chosen_step", want.chosen, rsp_ch.chosen_step);
        check_field("step_weight", want.weight, rsp_ch.step_weight);
        check_field("total_weight", want.total, rsp_ch.total_weight);
        check_field("step_count", want.count, rsp_ch.step_count);
        check_field("status", want.status, rsp_ch.status);
      end
    end
  end

  // Main sequence: reset, directed rows, full table under back-pressure,
  // then random sessions across the idling phases, then drain.
  initial begin : stimulus
    int r;
    rst                    <= 1'b1;
    req_ch.valid           <= 1'b0;
    req_ch.operation       <= ssmp_pkg::OP_NONE;
    req_ch.weight          <= '0;
    req_ch.last            <= 1'b0;
    req_ch.random_fraction <= '0;
    req_ch.query_index     <= '0;
    // reset state of the predictor mirrors the block after reset
    tot_sum  = '0;
    n_loaded = '0;
    tbl_done = 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    for (r = 0; r < N_DIRECTED; r++)
      send_word(directed_rows[r].word, directed_rows[r].typed, directed_rows[r].want);

    // no idling on either side while the hold-off backs the chain up
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    run_full_table();
    run_phase(0, 0);
    run_phase(58, 0);
    run_phase(0, 58);
    run_phase(23, 23);

    req_ch.valid <= 1'b0;
    rx_stall_pct = 0;
    while (awaited_results.size() != 0) @(posedge clk);
    // watch a full chain length more for stray results
    repeat (MAX_STEPS + 16) @(posedge clk);
    if (mismatches == 0) begin
      $display("step_distribution_sampler test passed");
    end else begin
      $display("step_distribution_sampler test failed");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("step_distribution_sampler test failed");
    $finish;
  end

endmodule

// File: step_distribution_sampler.f
design/ssmp_pkg.sv
design/ssmp_req_if.sv
design/ssmp_rsp_if.sv
design/ssmp_head.sv
design/ssmp_cell.sv
design/step_distribution_sampler.sv
sim/tb.sv
